/* sv/sfod_pkg.sv */
package sfod_pkg;

    // Width of the value fields on both channels.
    localparam int unsigned DATA_W = 64;

    // Control that travels with one transaction from cell to cell.
    typedef struct packed {
        logic valid;   // stage holds a transaction
        logic last;    // transaction closes its list
        logic hit;     // value matched a recorded entry upstream
        logic placed;  // value was recorded in an upstream cell
    } cell_flags_t;

endpackage

/* sv/sfod_if.sv */
interface sfod_item_if;
    logic                         valid;
    logic                         ready;
    logic [sfod_pkg::DATA_W-1:0]  item_value;
    logic                         end_of_list;

    modport source (output valid, output item_value, output end_of_list, input ready);
    modport sink   (input valid, input item_value, input end_of_list, output ready);
endinterface

interface sfod_result_if;
    logic                         valid;
    logic                         ready;
    logic [sfod_pkg::DATA_W-1:0]  echo_value;
    logic                         keep;
    logic                         list_done;
    logic                         changed;
    logic                         set_overflow;

    modport source (output valid, output echo_value, output keep, output list_done,
                    output changed, output set_overflow, input ready);
    modport sink   (input valid, input echo_value, input keep, input list_done,
                    input changed, input set_overflow, output ready);
endinterface

/* sv/sfod_cell.sv */
module sfod_cell #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  sfod_pkg::cell_flags_t    prev_flags,
    input  logic [VALUE_WIDTH-1:0]   prev_value,
    output sfod_pkg::cell_flags_t    next_flags,
    output logic [VALUE_WIDTH-1:0]   next_value
);

    logic [VALUE_WIDTH-1:0]  stored_reg;
    logic [VALUE_WIDTH-1:0]  stored_next;
    logic                    used_reg;
    logic                    used_next;
    sfod_pkg::cell_flags_t   flags_reg;
    sfod_pkg::cell_flags_t   flags_next;
    logic [VALUE_WIDTH-1:0]  value_reg;
    logic                    match;
    logic                    record;

    // Compare against the local entry; record into the first free cell reached.
    assign match  = used_reg && (stored_reg == prev_value);
    assign record = prev_flags.valid && !prev_flags.hit && !prev_flags.placed && !used_reg;

    always_comb
    begin
        stored_next = stored_reg;
        used_next   = used_reg;
        flags_next  = prev_flags;
        if (prev_flags.valid)
        begin
            flags_next.hit    = prev_flags.hit | match;
            flags_next.placed = prev_flags.placed | record;
            if (record)
            begin
                stored_next = prev_value;
                used_next   = 1'b1;
            end
            // drop the entry once the list's final transaction has passed
            if (prev_flags.last)
            begin
                used_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            flags_reg <= '0;
        end
        else if (advance)
        begin
            used_reg  <= used_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stored_reg <= stored_next;
            value_reg  <= prev_value;
        end
    end

    assign next_flags = flags_reg;
    assign next_value = value_reg;

    a_record_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && record && !prev_flags.last) |=> used_reg)
        else $error("recorded value not held in cell");

endmodule

/* sv/stream_first_occurrence_dedup.sv */
// Path: an accepted item passes through the register of every cell and then the result
// register; any stall on the result channel holds it on the way.
// Throughput: one item per cycle; the whole cell chain advances together and holds
// while a finished result waits to be taken.
// Reset: rst_n clears every cell's entry-in-use bit, the chain's stage-valid bits,
// the result valid bit and the sticky duplicate and overflow flags; no clearing pass.
module stream_first_occurrence_dedup #(
    parameter int unsigned SET_DEPTH   = 64,
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    sfod_item_if.sink      items,
    sfod_result_if.source  results
);

    // ------------------------------------------------------------------
    // Cell chain. While the chain advances, each transaction walks it one
    // cell per cycle and is compared against the entry held there. Entries
    // fill from cell 0 upward, so by the time a transaction reaches the first
    // free cell it has already met every recorded value; if it missed them
    // all it is recorded there. The next transaction trails one cell behind
    // and therefore always sees that update. A transaction that closes its
    // list empties each cell behind it, so the next list starts fresh.
    // ------------------------------------------------------------------
    sfod_pkg::cell_flags_t   chain_flags [SET_DEPTH+1];
    logic [VALUE_WIDTH-1:0]  chain_value [SET_DEPTH+1];
    logic                    advance;

    // Advance the chain whenever the result register is free or being drained.
    assign advance     = !results.valid || results.ready;
    assign items.ready = advance;

    // Feed the chain head: valid, last, no match yet, not recorded yet.
    assign chain_flags[0] = {items.valid, items.end_of_list, 1'b0, 1'b0};
    assign chain_value[0] = items.item_value[VALUE_WIDTH-1:0];

    for (genvar gi = 0; gi < SET_DEPTH; gi++)
    begin : g_cell
        sfod_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_flags (chain_flags[gi]),
            .prev_value (chain_value[gi]),
            .next_flags (chain_flags[gi+1]),
            .next_value (chain_value[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // Result stage: derive keep and the sticky list flags in list order.
    // ------------------------------------------------------------------
    sfod_pkg::cell_flags_t  tail_flags;
    logic [VALUE_WIDTH-1:0] tail_value;
    logic                   tail_overflow;

    assign tail_flags    = chain_flags[SET_DEPTH];
    assign tail_value    = chain_value[SET_DEPTH];
    // neither matched nor recorded: the set was full
    assign tail_overflow = !tail_flags.hit && !tail_flags.placed;

    logic                         res_valid_reg;
    logic                         res_valid_next;
    logic [sfod_pkg::DATA_W-1:0]  res_value_reg;
    logic                         res_keep_reg;
    logic                         res_done_reg;
    logic                         res_changed_reg;
    logic                         res_changed_next;
    logic                         res_ovf_reg;
    logic                         res_ovf_next;
    logic                         dropped_reg;
    logic                         dropped_next;
    logic                         ovf_reg;
    logic                         ovf_next;

    always_comb
    begin
        res_valid_next   = tail_flags.valid;
        res_changed_next = dropped_reg | tail_flags.hit;
        res_ovf_next     = ovf_reg | tail_overflow;
        dropped_next     = dropped_reg;
        ovf_next         = ovf_reg;
        if (tail_flags.valid)
        begin
            // clear the sticky flags after the list's final transaction
            dropped_next = tail_flags.last ? 1'b0 : res_changed_next;
            ovf_next     = tail_flags.last ? 1'b0 : res_ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            dropped_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= res_valid_next;
            dropped_reg   <= dropped_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail_flags.valid)
        begin
            res_value_reg   <= sfod_pkg::DATA_W'(tail_value);
            res_keep_reg    <= !tail_flags.hit;
            res_done_reg    <= tail_flags.last;
            res_changed_reg <= res_changed_next;
            res_ovf_reg     <= res_ovf_next;
        end
    end

    assign results.valid        = res_valid_reg;
    assign results.echo_value   = res_value_reg;
    assign results.keep         = res_keep_reg;
    assign results.list_done    = res_done_reg;
    assign results.changed      = res_changed_reg;
    assign results.set_overflow = res_ovf_reg;

    // A dropped duplicate must always show in the sticky flag.
    a_drop_sets_changed: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.keep) |-> results.changed)
        else $error("duplicate dropped without changed flag");

    // A transaction is never both matched and recorded.
    a_hit_or_placed: assert property (@(posedge clk) disable iff (!rst_n)
        tail_flags.valid |-> !(tail_flags.hit && tail_flags.placed))
        else $error("transaction both matched and recorded");

    // Sticky flags are clear after the list's final transaction leaves the chain.
    a_sticky_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tail_flags.valid && tail_flags.last) |=> (!dropped_reg && !ovf_reg))
        else $error("sticky flags not cleared at end of list");

endmodule
